[hw/rtl/vlsds_pkg.sv]
// ---------------------------------------------------------------------------
// vlsds_pkg: shared types and constants for the value list block
// Opcodes, status codes, controller states and field widths.
// ---------------------------------------------------------------------------
`default_nettype none
package vlsds_pkg;
	localparam int DEF_LIST_DEPTH = 64;
	localparam int VAL_W = 31;
	localparam int POS_W = 6;
	localparam int CNT_W = 7;

	typedef enum logic [2:0] {
		OP_APPEND   = 3'd0,
		OP_FIND     = 3'd1,
		OP_DEL_ONE  = 3'd2,
		OP_DEL_ALL  = 3'd3,
		OP_LIST     = 3'd4,
		OP_LIST_ASC = 3'd5,
		OP_LIST_DSC = 3'd6,
		OP_NONE     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOTFD = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_SH_RD,
		S_SH_EV,
		S_EMIT
	} state_t;
endpackage
`default_nettype wire

[hw/rtl/vlsds_store.sv]
// ---------------------------------------------------------------------------
// vlsds_store: entry memory
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none
module vlsds_store #(
	parameter int DEPTH = vlsds_pkg::DEF_LIST_DEPTH,
	parameter int AW = 6
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic [vlsds_pkg::VAL_W-1:0] wdata,
	input  wire logic [AW-1:0]              raddr,
	output logic      [vlsds_pkg::VAL_W-1:0] rdata
);
	import vlsds_pkg::*;

	logic [VAL_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/value_list_search_delete_sort.sv]
// ---------------------------------------------------------------------------
// value_list_search_delete_sort: ordered value list with search and sort
// Append, find, delete first, delete all and three kinds of listing over
// a list kept in one synchronous memory with a fill count.
// ---------------------------------------------------------------------------
// Flow: append and commands on an empty list go from idle straight to the emit
// state. Find and delete walk the entries with a read state and a compare
// state per entry; delete first then shifts later entries, one read and write each.
// Stored listing emits one result per entry read; sorted listings scan the
// whole list once per result, set by the single memory read port. Results
// wait in the emit state while the output register is held. Reset empties the list; memory is not cleared.
`default_nettype none
module value_list_search_delete_sort #(
	parameter int LIST_DEPTH = vlsds_pkg::DEF_LIST_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	output logic                              cmd_ready,
	input  wire logic [2:0]                   opcode,
	input  wire logic [vlsds_pkg::VAL_W-1:0]  operand_value,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic      [1:0]                   status,
	output logic      [vlsds_pkg::VAL_W-1:0]  item_value,
	output logic      [vlsds_pkg::POS_W-1:0]  position,
	output logic      [vlsds_pkg::CNT_W-1:0]  removed_count,
	output logic                              last_flag
);
	import vlsds_pkg::*;

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int KW = VAL_W + AW;

	state_t state_q, state_d, ret_q, ret_d;
	op_t op_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0] fill_q, fill_d, i_q, i_d, j_q, j_d, k_q, k_d;
	logic [AW-1:0] first_q, first_d;
	logic found_q, found_d, has_prev_q, has_prev_d;
	logic [KW-1:0] best_q, best_d, prev_q, prev_d;

	// Pending result.
	logic [1:0] rs_st_q, rs_st_d;
	logic [VAL_W-1:0] rs_val_q, rs_val_d;
	logic [AW-1:0] rs_pos_q, rs_pos_d;
	logic [CW-1:0] rs_cnt_q, rs_cnt_d;
	logic rs_last_q, rs_last_d;

	// Output register.
	logic out_v_q;
	logic [1:0] out_st_q;
	logic [VAL_W-1:0] out_val_q;
	logic [AW-1:0] out_pos_q;
	logic [CW-1:0] out_cnt_q;
	logic out_last_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [VAL_W-1:0] mem_wdata, rdata;

	logic take, slot_free, emit;
	logic [CW-1:0] i_inc, i_inc2, j_inc;
	logic at_last, hit, qual, better, asc;
	logic [KW-1:0] key, best_n;

	vlsds_store #(.DEPTH(LIST_DEPTH), .AW(AW)) u_store (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(rdata)
	);

	assign cmd_ready = (state_q == S_IDLE);
	assign take = cmd_valid && cmd_ready;
	assign slot_free = !out_v_q || res_ready;

	// Scan helpers.
	assign i_inc = i_q + CW'(1);
	assign i_inc2 = i_q + CW'(2);
	assign j_inc = j_q + CW'(1);
	assign at_last = (i_inc == fill_q);
	assign hit = (rdata == val_q);
	assign asc = (op_q == OP_LIST_ASC);
	assign key = {rdata, i_q[AW-1:0]};
	assign qual = !has_prev_q || (asc ? (key > prev_q) : (key < prev_q));
	assign better = !found_q || (asc ? (key < best_q) : (key > best_q));
	assign best_n = (qual && better) ? key : best_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		unique case (state_q)
			S_IDLE: begin
				if (take && op_t'(opcode) != OP_NONE) begin
					if (op_t'(opcode) == OP_APPEND || fill_q == '0) begin
						state_d = S_EMIT;
						ret_d = S_IDLE;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_RD: state_d = S_EV;
			S_EV: begin
				case (op_q)
					OP_FIND: begin
						if (hit || at_last) begin
							state_d = S_EMIT;
							ret_d = S_IDLE;
						end else begin
							state_d = S_RD;
						end
					end
					OP_DEL_ONE: begin
						if (hit && !at_last) begin
							state_d = S_SH_RD;
						end else if (hit || at_last) begin
							state_d = S_EMIT;
							ret_d = S_IDLE;
						end else begin
							state_d = S_RD;
						end
					end
					OP_DEL_ALL: begin
						if (at_last) begin
							state_d = S_EMIT;
							ret_d = S_IDLE;
						end else begin
							state_d = S_RD;
						end
					end
					OP_LIST: begin
						state_d = S_EMIT;
						ret_d = at_last ? S_IDLE : S_RD;
					end
					default: begin
						if (at_last) begin
							state_d = S_EMIT;
							ret_d = (k_q + CW'(1) == fill_q) ? S_IDLE : S_RD;
						end else begin
							state_d = S_RD;
						end
					end
				endcase
			end
			S_SH_RD: state_d = S_SH_EV;
			S_SH_EV: begin
				if (i_inc2 == fill_q) begin
					state_d = S_EMIT;
					ret_d = S_IDLE;
				end else begin
					state_d = S_SH_RD;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					state_d = ret_q;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory control, datapath updates and result preparation.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = fill_q[AW-1:0];
		mem_wdata = val_q;
		mem_raddr = i_q[AW-1:0];
		emit = 1'b0;
		fill_d = fill_q;
		i_d = i_q;
		j_d = j_q;
		k_d = k_q;
		first_d = first_q;
		found_d = found_q;
		has_prev_d = has_prev_q;
		best_d = best_q;
		prev_d = prev_q;
		rs_st_d = rs_st_q;
		rs_val_d = rs_val_q;
		rs_pos_d = rs_pos_q;
		rs_cnt_d = rs_cnt_q;
		rs_last_d = rs_last_q;
		unique case (state_q)
			S_IDLE: begin
				i_d = '0;
				j_d = '0;
				k_d = '0;
				found_d = 1'b0;
				has_prev_d = 1'b0;
				rs_val_d = operand_value;
				rs_last_d = 1'b1;
				rs_pos_d = '0;
				if (take && op_t'(opcode) == OP_APPEND) begin
					if (fill_q == CW'(LIST_DEPTH)) begin
						rs_st_d = ST_FULL;
						rs_cnt_d = fill_q;
					end else begin
						mem_we = 1'b1;
						mem_waddr = fill_q[AW-1:0];
						mem_wdata = operand_value;
						fill_d = fill_q + CW'(1);
						rs_st_d = ST_OK;
						rs_pos_d = fill_q[AW-1:0];
						rs_cnt_d = fill_q + CW'(1);
					end
				end else if (take && fill_q == '0) begin
					rs_st_d = ST_EMPTY;
					rs_cnt_d = '0;
					if (op_t'(opcode) == OP_LIST || op_t'(opcode) == OP_LIST_ASC ||
							op_t'(opcode) == OP_LIST_DSC) begin
						rs_val_d = '0;
					end
				end
			end
			S_RD: begin
				mem_raddr = i_q[AW-1:0];
			end
			S_EV: begin
				case (op_q)
					OP_FIND, OP_DEL_ONE: begin
						if (hit) begin
							rs_st_d = ST_OK;
							rs_pos_d = i_q[AW-1:0];
							first_d = i_q[AW-1:0];
							if (op_q == OP_DEL_ONE && at_last) begin
								fill_d = fill_q - CW'(1);
								rs_cnt_d = fill_q - CW'(1);
							end else begin
								rs_cnt_d = fill_q;
							end
						end else if (at_last) begin
							rs_st_d = ST_NOTFD;
							rs_pos_d = '0;
							rs_cnt_d = fill_q;
						end else begin
							i_d = i_inc;
						end
					end
					OP_DEL_ALL: begin
						// Compact survivors toward the front.
						if (!hit) begin
							mem_we = 1'b1;
							mem_waddr = j_q[AW-1:0];
							mem_wdata = rdata;
							j_d = j_inc;
						end else if (!found_q) begin
							found_d = 1'b1;
							first_d = i_q[AW-1:0];
						end
						i_d = i_inc;
						if (at_last) begin
							if (found_q || hit) begin
								fill_d = hit ? j_q : j_inc;
								rs_st_d = ST_OK;
								rs_pos_d = found_q ? first_q : i_q[AW-1:0];
								rs_cnt_d = fill_q - (hit ? j_q : j_inc);
							end else begin
								rs_st_d = ST_NOTFD;
								rs_pos_d = '0;
								rs_cnt_d = '0;
							end
						end
					end
					OP_LIST: begin
						rs_st_d = ST_OK;
						rs_val_d = rdata;
						rs_pos_d = i_q[AW-1:0];
						rs_cnt_d = fill_q;
						rs_last_d = at_last;
						i_d = i_inc;
					end
					default: begin
						// Selection over (value, index) pairs: one full scan per rank.
						// A candidate is held only once a qualifying key has been seen.
						best_d = best_n;
						found_d = found_q || qual;
						i_d = i_inc;
						if (at_last) begin
							rs_st_d = ST_OK;
							rs_val_d = best_n[KW-1:AW];
							rs_pos_d = k_q[AW-1:0];
							rs_cnt_d = fill_q;
							rs_last_d = (k_q + CW'(1) == fill_q);
							prev_d = best_n;
							has_prev_d = 1'b1;
							found_d = 1'b0;
							k_d = k_q + CW'(1);
							i_d = '0;
						end
					end
				endcase
			end
			S_SH_RD: begin
				mem_raddr = i_inc[AW-1:0];
			end
			S_SH_EV: begin
				mem_we = 1'b1;
				mem_waddr = i_q[AW-1:0];
				mem_wdata = rdata;
				i_d = i_inc;
				if (i_inc2 == fill_q) begin
					fill_d = fill_q - CW'(1);
					rs_cnt_d = fill_q - CW'(1);
				end
			end
			S_EMIT: begin
				emit = slot_free;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			fill_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			fill_q <= fill_d;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (take) begin
			op_q <= op_t'(opcode);
			val_q <= operand_value;
		end
		i_q <= i_d;
		j_q <= j_d;
		k_q <= k_d;
		first_q <= first_d;
		found_q <= found_d;
		has_prev_q <= has_prev_d;
		best_q <= best_d;
		prev_q <= prev_d;
		rs_st_q <= rs_st_d;
		rs_val_q <= rs_val_d;
		rs_pos_q <= rs_pos_d;
		rs_cnt_q <= rs_cnt_d;
		rs_last_q <= rs_last_d;
		if (emit) begin
			out_st_q <= rs_st_q;
			out_val_q <= rs_val_q;
			out_pos_q <= rs_pos_q;
			out_cnt_q <= rs_cnt_q;
			out_last_q <= rs_last_q;
		end
	end

	assign res_valid = out_v_q;
	assign status = out_st_q;
	assign item_value = out_val_q;
	assign position = POS_W'(out_pos_q);
	assign removed_count = CNT_W'(out_cnt_q);
	assign last_flag = out_last_q;

	// The fill count never passes the capacity.
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(LIST_DEPTH))
		else $error("fill count above capacity");

	// An append into a list with room grows it by one.
	a_append_grow: assert property (@(posedge clk) disable iff (!arst_n)
		take && op_t'(opcode) == OP_APPEND && fill_q != CW'(LIST_DEPTH)
		|=> fill_q == $past(fill_q) + CW'(1))
		else $error("append did not grow the list");

	// Memory writes stay inside the held entries, except an append.
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q != S_IDLE |-> CW'(mem_waddr) < fill_q)
		else $error("write outside the held entries");

	// A result is loaded only from the emit state.
	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> state_q == S_EMIT && slot_free)
		else $error("result loaded outside emit");
endmodule
`default_nettype wire

[tb/tb_value_list_search_delete_sort.sv]
// ---------------------------------------------------------------------------
// tb_value_list_search_delete_sort: self-checking bench for the value list
// Drives command words with bursty timing, stalls the result side on its own
// pattern, predicts every result from a private copy of the list and checks
// results in order through a small scoreboard class.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_value_list_search_delete_sort;
	import vlsds_pkg::*;

	localparam int DEPTH = 64;
	localparam int STALL_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]       st;
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} list_result_t;

	// Scoreboard: holds the list model and the queue of expected results.
	class list_scoreboard;
		logic [VAL_W-1:0] entries[DEPTH];
		int fill;
		list_result_t pending[$];
		int errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function void push(logic [1:0] st, logic [VAL_W-1:0] val, int pos, int cnt,
			logic last);
			list_result_t r;
			r.st = st;
			r.val = val;
			r.pos = pos[POS_W-1:0];
			r.cnt = cnt[CNT_W-1:0];
			r.last = last;
			pending.push_back(r);
		endfunction

		// Note an accepted command word and queue the results it causes.
		function void note_command(logic [2:0] op, logic [VAL_W-1:0] v);
			int idx;
			int j;
			logic [VAL_W-1:0] buf_q[$];
			idx = -1;
			for (int i = 0; i < fill; i++) begin
				if (idx < 0 && entries[i] == v) idx = i;
			end
			case (op)
				OP_APPEND: begin
					if (fill >= DEPTH) push(ST_FULL, v, 0, fill, 1'b1);
					else begin
						entries[fill] = v;
						fill++;
						push(ST_OK, v, fill - 1, fill, 1'b1);
					end
				end
				OP_FIND, OP_DEL_ONE: begin
					if (fill == 0) push(ST_EMPTY, v, 0, 0, 1'b1);
					else if (idx < 0) push(ST_NOTFD, v, 0, fill, 1'b1);
					else begin
						if (op == OP_DEL_ONE) begin
							for (int i = idx; i + 1 < fill; i++) entries[i] = entries[i + 1];
							fill--;
						end
						push(ST_OK, v, idx, fill, 1'b1);
					end
				end
				OP_DEL_ALL: begin
					if (fill == 0) push(ST_EMPTY, v, 0, 0, 1'b1);
					else if (idx < 0) push(ST_NOTFD, v, 0, 0, 1'b1);
					else begin
						j = 0;
						for (int i = 0; i < fill; i++)
							if (entries[i] != v) begin
								entries[j] = entries[i];
								j++;
							end
						push(ST_OK, v, idx, fill - j, 1'b1);
						fill = j;
					end
				end
				OP_LIST, OP_LIST_ASC, OP_LIST_DSC: begin
					if (fill == 0) push(ST_EMPTY, '0, 0, 0, 1'b1);
					else begin
						for (int i = 0; i < fill; i++) buf_q.push_back(entries[i]);
						if (op == OP_LIST_ASC) buf_q.sort();
						if (op == OP_LIST_DSC) buf_q.rsort();
						for (int i = 0; i < fill; i++)
							push(ST_OK, buf_q[i], i, fill, i + 1 == fill);
					end
				end
				default: ;
			endcase
		endfunction

		// Compare one accepted result against the oldest expectation.
		function void check_result(list_result_t got);
			list_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.st != e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, got.st);
				errors++;
			end
			if (got.val != e.val) begin
				$display("%0t: item_value expected %0d actual %0d", $time, e.val, got.val);
				errors++;
			end
			if (got.pos != e.pos) begin
				$display("%0t: position expected %0d actual %0d", $time, e.pos, got.pos);
				errors++;
			end
			if (got.cnt != e.cnt) begin
				$display("%0t: removed_count expected %0d actual %0d", $time, e.cnt, got.cnt);
				errors++;
			end
			if (got.last != e.last) begin
				$display("%0t: last_flag expected %0d actual %0d", $time, e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cmd_valid, cmd_ready, res_valid, res_ready;
	logic [2:0] opcode;
	logic [VAL_W-1:0] operand_value, item_value;
	logic [1:0] status;
	logic [POS_W-1:0] position;
	logic [CNT_W-1:0] removed_count;
	logic last_flag;

	list_scoreboard board;
	bit hold_off;
	int idle_cycles;
	logic [VAL_W-1:0] pool[8];

	value_list_search_delete_sort #(.LIST_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.opcode(opcode), .operand_value(operand_value),
		.res_valid(res_valid), .res_ready(res_ready),
		.status(status), .item_value(item_value), .position(position),
		.removed_count(removed_count), .last_flag(last_flag)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one command word and wait until it is taken.
	task automatic send_word(logic [2:0] op, logic [VAL_W-1:0] v);
		cmd_valid <= 1'b1;
		opcode <= op;
		operand_value <= v;
		do @(posedge clk); while (!cmd_ready);
		board.note_command(op, v);
	endtask

	task automatic pause_sender(int n);
		cmd_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: return VAL_W'($urandom());
			1: return '1;
			default: return pool[$urandom_range(0, 7)];
		endcase
	endfunction

	// Receiver: stalls in a pattern, plus one long hold-off.
	always @(posedge clk) begin
		if (!arst_n) res_ready <= 1'b0;
		else if (hold_off) res_ready <= 1'b0;
		else res_ready <= ($urandom_range(0, 9) < 6) || ($time / 4000) % 3 == 0;
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			board.check_result('{status, item_value, position, removed_count, last_flag});
	end

	// Watchdog on cycles with no accepted word of either kind.
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("value_list_search_delete_sort test failed");
			$finish;
		end
	end

	initial begin
		repeat (20) @(posedge clk);
		hold_off = 1'b1;
		repeat (3000) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		int burst;
		int r;
		board = new();
		hold_off = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		opcode = '0;
		operand_value = '0;
		res_ready = 1'b0;
		for (int i = 0; i < 8; i++) pool[i] = VAL_W'($urandom_range(0, 5));
		pool[7] = '1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list cases, extremes, duplicates, every listing.
		send_word(OP_FIND, 5);
		send_word(OP_DEL_ONE, 5);
		send_word(OP_DEL_ALL, 5);
		send_word(OP_LIST, 0);
		send_word(OP_LIST_ASC, 0);
		send_word(OP_LIST_DSC, '1);
		send_word(OP_NONE, 3);
		send_word(OP_APPEND, '1);
		send_word(OP_APPEND, 0);
		send_word(OP_APPEND, 7);
		send_word(OP_APPEND, 0);
		send_word(OP_APPEND, 'h2AAAAAAA);
		send_word(OP_APPEND, 'h55555555);
		send_word(OP_LIST, 0);
		send_word(OP_LIST_ASC, 9);
		send_word(OP_LIST_DSC, 0);
		send_word(OP_FIND, 0);
		send_word(OP_FIND, 99);
		send_word(OP_DEL_ONE, 7);
		send_word(OP_DEL_ALL, 0);
		send_word(OP_DEL_ALL, 99);
		send_word(OP_DEL_ONE, 99);
		send_word(OP_LIST, 0);
		// Fill to capacity, then one append past full.
		for (int i = 0; i < DEPTH - 3; i++)
			send_word(OP_APPEND, VAL_W'($urandom_range(0, 3)));
		send_word(OP_APPEND, 1);
		send_word(OP_LIST_ASC, 0);
		send_word(OP_DEL_ALL, 1);
		send_word(OP_LIST_DSC, 0);

		// Random: bursts of mostly appends and searches, listings kept rare.
		burst = 0;
		for (int n = 0; n < 212; n++) begin
			if (burst == 0) begin
				if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 20));
				burst = $urandom_range(1, 12);
			end
			burst--;
			r = $urandom_range(0, 99);
			if (r < 40) send_word(OP_APPEND, pick_value());
			else if (r < 55) send_word(OP_FIND, pick_value());
			else if (r < 70) send_word(OP_DEL_ONE, pick_value());
			else if (r < 82) send_word(OP_DEL_ALL, pick_value());
			else if (r < 88) send_word(OP_LIST, VAL_W'($urandom()));
			else if (r < 93) send_word(OP_LIST_ASC, VAL_W'($urandom()));
			else if (r < 98) send_word(OP_LIST_DSC, VAL_W'($urandom()));
			else send_word(OP_NONE, VAL_W'($urandom()));
		end
		cmd_valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("value_list_search_delete_sort test passed");
		else
			$display("value_list_search_delete_sort test failed");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
hw/rtl/vlsds_pkg.sv
hw/rtl/vlsds_store.sv
hw/rtl/value_list_search_delete_sort.sv
tb/tb_value_list_search_delete_sort.sv
